[rtl/sha256_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int WordW = 32;
  localparam int NumRounds = 64;
  localparam int NumWords = 8;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_LOAD,
    CMD_ROUND,
    CMD_FOLD,
    CMD_RESTART
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [5:0]  pos;
    logic [7:0]  wr_byte;
    logic [5:0]  round;
    logic        clr_len;
    logic        inc_len;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0]  pos;
  } dp_status_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[rtl/sha256_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, length counter, schedule window, round registers, chain value.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  sha256_pkg::dp_cmd_t   cmd,
  output sha256_pkg::dp_status_t status,
  output sha256_pkg::word_t     chain_out [8],
  output logic [63:0]           bit_len
);

  sha256_pkg::word_t  buffer [16];
  logic [63:0]        msg_len;
  sha256_pkg::word_t  chain [8];
  sha256_pkg::word_t  wv [8];
  sha256_pkg::word_t  sched [16];
  sha256_pkg::word_t  w_cur;
  sha256_pkg::word_t  w_new;
  sha256_pkg::word_t  t1;
  sha256_pkg::word_t  t2;

  assign status.pos = msg_len[5:0];
  assign bit_len = {msg_len[60:0], 3'b000};
  assign chain_out = chain;

  always_comb begin
    w_new = sched[0] + sha256_pkg::ssig0(sched[1]) + sched[9] + sha256_pkg::ssig1(sched[14]);
    w_cur = (cmd.round < 6'd16) ? sched[0] : w_new;
    t1 = wv[7] + sha256_pkg::bsig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
       + sha256_pkg::RoundK[cmd.round] + w_cur;
    t2 = sha256_pkg::bsig0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.op == sha256_pkg::CMD_WRITE) begin
      buffer[cmd.pos[5:2]][{~cmd.pos[1:0], 3'b000} +: 8] <= cmd.wr_byte;
    end
    if (cmd.op == sha256_pkg::CMD_LOAD) begin
      sched <= buffer;
      wv <= chain;
    end
    if (cmd.op == sha256_pkg::CMD_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[15] <= w_cur;
      for (int i = 1; i < 8; i++) begin
        if (i != 4) begin
          wv[i] <= wv[i-1];
        end
      end
      wv[4] <= wv[3] + t1;
      wv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_len <= '0;
      chain <= sha256_pkg::InitH;
    end else begin
      if (cmd.inc_len) begin
        msg_len <= msg_len + 64'd1;
      end else if (cmd.clr_len) begin
        msg_len <= '0;
      end
      if (cmd.op == sha256_pkg::CMD_FOLD) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + wv[i];
        end
      end else if (cmd.op == sha256_pkg::CMD_RESTART) begin
        chain <= sha256_pkg::InitH;
      end
    end
  end

endmodule

[rtl/sha256_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorb, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [7:0]             data_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             word_index,
  output logic                   last_word,
  output sha256_pkg::dp_cmd_t    cmd,
  input  sha256_pkg::dp_status_t status,
  input  logic [63:0]            bit_len
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  state_t     state;
  logic [5:0] wpos;
  logic [5:0] round;
  logic       finishing;
  logic       extra;
  logic [2:0] idx;
  logic       accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign word_index = idx;
  assign last_word = (idx == 3'd7);

  always_comb begin
    cmd = '0;
    cmd.op = sha256_pkg::CMD_NONE;
    cmd.round = round;
    cmd.pos = wpos;
    case (state)
      S_IDLE: begin
        if (accept && !func) begin
          cmd.op = sha256_pkg::CMD_WRITE;
          cmd.pos = status.pos;
          cmd.wr_byte = data_byte;
          cmd.inc_len = 1'b1;
        end else if (accept) begin
          cmd.op = sha256_pkg::CMD_WRITE;
          cmd.pos = status.pos;
          cmd.wr_byte = sha256_pkg::PadByte;
        end
      end
      S_PAD: begin
        cmd.op = sha256_pkg::CMD_WRITE;
        if (!extra && wpos >= 6'd56) begin
          cmd.wr_byte = bit_len[8*(63 - wpos) +: 8];
        end else begin
          cmd.wr_byte = 8'h00;
        end
      end
      S_LOAD:  cmd.op = sha256_pkg::CMD_LOAD;
      S_ROUND: cmd.op = sha256_pkg::CMD_ROUND;
      S_FOLD:  cmd.op = sha256_pkg::CMD_FOLD;
      S_EMIT: begin
        if (!out_stall && idx == 3'd7) begin
          cmd.op = sha256_pkg::CMD_RESTART;
          cmd.clr_len = 1'b1;
        end
      end
      default: cmd.op = sha256_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wpos <= '0;
      round <= '0;
      finishing <= 1'b0;
      extra <= 1'b0;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && !func) begin
            finishing <= 1'b0;
            if (status.pos == 6'd63) begin
              state <= S_LOAD;
            end
          end else if (accept) begin
            finishing <= 1'b1;
            extra <= (status.pos >= 6'd56);
            if (status.pos == 6'd63) begin
              state <= S_LOAD;
            end else begin
              wpos <= status.pos + 6'd1;
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          wpos <= wpos + 6'd1;
          if (wpos == 6'd63) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          round <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (!finishing) begin
            state <= S_IDLE;
          end else if (extra) begin
            extra <= 1'b0;
            wpos <= '0;
            state <= S_PAD;
          end else begin
            idx <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              finishing <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/sha256_stream_hash_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hash top level
// Byte-wide SHA-256 with digest output as eight 32-bit words.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with func and data_byte. func 0 absorbs
// one byte, func 1 pads the message and starts digest output.
// Output channel: out_valid/out_stall with digest_word, word_index and
// last_word; eight items per finish, word 0 first, last_word on word 7.
// A data byte is taken while idle; the 64th byte of a block starts a
// compression (load, 64 rounds on the single round unit, fold) during
// which input stalls. A finish writes the padding, compresses one block,
// or two when the length does not fit, then sends the eight digest words.
// in_stall is high whenever a block is compressing, padding or the digest
// is being sent. A stall on the output holds the current word.
// Reset loads the initial hash values and clears the length; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module sha256_stream_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha256_pkg::dp_cmd_t    cmd;
  sha256_pkg::dp_status_t status;
  sha256_pkg::word_t      chain [8];
  logic [63:0]            bit_len;

  sha256_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .func, .data_byte,
    .out_valid, .out_stall, .word_index, .last_word,
    .cmd, .status, .bit_len
  );

  sha256_dp u_dp (
    .clk, .rst, .cmd, .status, .chain_out(chain), .bit_len
  );

  assign digest_word = chain[word_index];

endmodule

[rtl/sha256_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Port-level properties of the stream hash top level.
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("output item changed under stall");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word mismatch");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest words out of order");

  a_no_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during digest output");

endmodule

bind sha256_stream_hash_top sha256_checker u_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .digest_word, .word_index, .last_word
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hash testbench
// Feeds byte and finish items through the valid/stall input channel, predicts
// each digest with a local SHA-256 model and checks every output word in order
// while the input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic {FN_ABSORB = 1'b0, FN_FINISH = 1'b1} fn_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  class digest_board;
    sha256_pkg::word_t hval [8];
    logic [7:0]        buf_bytes [64];
    logic [63:0]       byte_count;
    digest_item_t      pending [$];
    int                errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) hval[i] = sha256_pkg::InitH[i];
      byte_count = 0;
    endfunction

    function sha256_pkg::word_t ror(sha256_pkg::word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      sha256_pkg::word_t w [64];
      sha256_pkg::word_t v [8];
      sha256_pkg::word_t t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {buf_bytes[4*i], buf_bytes[4*i+1], buf_bytes[4*i+2], buf_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
             + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = hval[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int j = 7; j > 0; j--) v[j] = v[j-1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hval[i] = hval[i] + v[i];
    endfunction

    function void note_input(fn_t fn, logic [7:0] b);
      int unsigned pos;
      logic [63:0] bits;
      digest_item_t d;
      pos = byte_count[5:0];
      if (fn == FN_ABSORB) begin
        buf_bytes[pos] = b;
        byte_count++;
        if (pos == 63) compress();
        return;
      end
      buf_bytes[pos] = sha256_pkg::PadByte;
      for (int i = pos + 1; i < 64; i++) buf_bytes[i] = 8'h00;
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 56; i++) buf_bytes[i] = 8'h00;
      end
      bits = byte_count << 3;
      for (int i = 0; i < 8; i++) buf_bytes[56+i] = bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        d.word = hval[i];
        d.idx = 3'(i);
        d.last = (i == 7);
        pending.push_back(d);
      end
      restart();
    endfunction

    function void check_word(logic [31:0] w, logic [2:0] idx, logic last);
      digest_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h idx %0d last %0d", $time, w, idx, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (w !== e.word) begin
        $display("%0t: digest_word expected %h actual %h", $time, e.word, w);
        errors++;
      end
      if (idx !== e.idx) begin
        $display("%0t: word_index expected %0d actual %0d", $time, e.idx, idx);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_word expected %0d actual %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_board board = new();
  bit          hold_out = 1'b0;
  int          quiet_cycles = 0;
  localparam int WatchLimit = 5000;

  sha256_stream_hash_top uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_item(fn_t fn, logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(fn, b);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(FN_ABSORB, 8'($urandom_range(0, 255)));
    send_item(FN_FINISH, 8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_word(digest_word, word_index, last_word);
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("sha256_stream_hash_top: mismatch");
      $finish;
    end
  end

  initial begin : out_side
    int wait_n;
    @(negedge rst);
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_item(FN_FINISH, 8'hff);
    send_item(FN_ABSORB, 8'h00);
    send_item(FN_ABSORB, 8'hff);
    send_item(FN_ABSORB, 8'ha5);
    send_item(FN_FINISH, 8'h00);
    hold_out = 1'b1;
    send_message(56);
    send_message(63);
    send_message(64);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    for (int m = 0; m < 4; m++) send_message(int'($urandom_range(0, 20)));
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0)
      $display("sha256_stream_hash_top: match");
    else
      $display("sha256_stream_hash_top: mismatch");
    $finish;
  end
endmodule
